// ===== rtl/hxtl_pkg.sv =====
// ----------------------------------------------------------------------------
// hxtl_pkg
// Shared widths, constants and types for the hex8 trilinear interpolator.
// ----------------------------------------------------------------------------
package hxtl_pkg;

   // node count and field widths
   localparam int NODE_COUNT = 8;
   localparam int COORD_W    = 16;
   localparam int VALUE_W    = 32;
   localparam int CFG_W      = 24;
   localparam int SIGN_W     = 3;
   localparam logic [CFG_W-1:0] CFG_RESET = 24'd14599368;

   // one in Q2.14, held at the corner factor width
   localparam int FACT_W = 18;
   localparam logic signed [FACT_W-1:0] ONE_Q14 = 18'sd16384;

   // product widths
   localparam int PAIR_W   = 2 * FACT_W;             // f * f
   localparam int VF0_W    = VALUE_W + FACT_W;       // v * f0
   localparam int SPLIT    = 25;                     // low half of v * f0
   localparam int VAL_LO_W = SPLIT + 1 + PAIR_W;     // unsigned low half * pair
   localparam int VAL_HI_W = VF0_W - SPLIT + PAIR_W; // signed high half * pair
   localparam int GRAD_P_W = VALUE_W + PAIR_W;       // v * signed pair

   // node sum widths (three levels of pairwise adds plus margin)
   localparam int LO_SUM_W   = VAL_LO_W + 4;
   localparam int HI_SUM_W   = VAL_HI_W + 4;
   localparam int GRAD_SUM_W = GRAD_P_W + 4;
   localparam int VAL_ACC_W  = HI_SUM_W + SPLIT;

   // final scaling of the exact sums down to Q16.16
   localparam int VALUE_SHIFT = 45;
   localparam int GRAD_SHIFT  = 31;

   // register stages from accept to result
   localparam int PIPE_DEPTH = 8;

   // saturation limits
   localparam logic [VALUE_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] SAT_MIN = 32'h8000_0000;

   // per-node products handed to the adder tree
   typedef struct packed {
      logic signed [VAL_HI_W-1:0] val_hi;
      logic signed [VAL_LO_W-1:0] val_lo;
      logic signed [GRAD_P_W-1:0] grad_x;
      logic signed [GRAD_P_W-1:0] grad_y;
      logic signed [GRAD_P_W-1:0] grad_z;
   } node_prod_type;

endpackage

// ===== rtl/hxtl_node_mul.sv =====
// ----------------------------------------------------------------------------
// hxtl_node_mul
// Two-stage multiplier slice for one node: shape factors, their pair
// products and the value times f0, then the products with the nodal value.
// ----------------------------------------------------------------------------
module hxtl_node_mul
   import hxtl_pkg::*;
(
   input  logic                      clock,
   input  logic [SIGN_W-1:0]         sign,
   input  logic signed [COORD_W-1:0] coord_xi,
   input  logic signed [COORD_W-1:0] coord_eta,
   input  logic signed [COORD_W-1:0] coord_zeta,
   input  logic signed [VALUE_W-1:0] node_value,
   output node_prod_type             prod
);

   logic signed [FACT_W-1:0] f0, f1, f2;
   logic signed [FACT_W-1:0] f1_sx, f0_sy, f0_sz;

   logic signed [PAIR_W-1:0]  p12_ff, p12_in;
   logic signed [PAIR_W-1:0]  q12_ff, q12_in;
   logic signed [PAIR_W-1:0]  q02_ff, q02_in;
   logic signed [PAIR_W-1:0]  q01_ff, q01_in;
   logic signed [VF0_W-1:0]   vf0_ff, vf0_in;
   logic signed [VALUE_W-1:0] v_ff;

   node_prod_type prod_ff, prod_in;

   // corner factors (1 + s*c) in Q2.14, then sign-folded copies
   always_comb begin
      f0 = sign[0] ? ONE_Q14 + FACT_W'(coord_xi)   : ONE_Q14 - FACT_W'(coord_xi);
      f1 = sign[1] ? ONE_Q14 + FACT_W'(coord_eta)  : ONE_Q14 - FACT_W'(coord_eta);
      f2 = sign[2] ? ONE_Q14 + FACT_W'(coord_zeta) : ONE_Q14 - FACT_W'(coord_zeta);
      f1_sx = sign[0] ? f1 : -f1;
      f0_sy = sign[1] ? f0 : -f0;
      f0_sz = sign[2] ? f0 : -f0;
   end

   // stage 1: pair products and value times first factor
   always_comb begin
      p12_in = f1 * f2;
      q12_in = f1_sx * f2;
      q02_in = f0_sy * f2;
      q01_in = f0_sz * f1;
      vf0_in = node_value * f0;
   end

   always_ff @(posedge clock) begin
      p12_ff <= p12_in;
      q12_ff <= q12_in;
      q02_ff <= q02_in;
      q01_ff <= q01_in;
      vf0_ff <= vf0_in;
      v_ff   <= node_value;
   end

   // stage 2: value term split in two halves, gradient terms direct
   always_comb begin
      prod_in.val_lo = $signed({1'b0, vf0_ff[SPLIT-1:0]}) * p12_ff;
      prod_in.val_hi = $signed(vf0_ff[VF0_W-1:SPLIT]) * p12_ff;
      prod_in.grad_x = v_ff * q12_ff;
      prod_in.grad_y = v_ff * q02_ff;
      prod_in.grad_z = v_ff * q01_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/hex8_trilinear_interpolate_grad.sv =====
// ----------------------------------------------------------------------------
// hex8_trilinear_interpolate_grad
// Hex8 trilinear interpolation of a nodal scalar with its local gradient.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_coord_* (Q2.14) and req_node_value_0..7 (Q16.16) and
//   pulse start. A word is taken on each clock edge with start high and busy
//   low; busy is high only while reset is asserted, so one word per cycle.
//   Response: rsp_valid is high for one cycle with interp_value and the three
//   local gradients (Q16.16, rounded to nearest, ties up, saturated).
//   Pipeline: a word goes through the input register, the two multiplier
//   stages per node, the three-level node adder tree and the round/saturate
//   stages; throughput one word per cycle.
//   The receiver cannot stall; every result shows for exactly one cycle.
//   Config: csr_wdata holds three corner sign bits per node (bit set = +1),
//   written when csr_valid and csr_ready are high; write only while idle.
//   Reset: clears the pipeline valid bits, dropping words in flight, and
//   loads the usual node order into the sign table.
// ----------------------------------------------------------------------------
module hex8_trilinear_interpolate_grad
   import hxtl_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_coord_xi,
   input  logic signed [COORD_W-1:0] req_coord_eta,
   input  logic signed [COORD_W-1:0] req_coord_zeta,
   input  logic signed [VALUE_W-1:0] req_node_value_0,
   input  logic signed [VALUE_W-1:0] req_node_value_1,
   input  logic signed [VALUE_W-1:0] req_node_value_2,
   input  logic signed [VALUE_W-1:0] req_node_value_3,
   input  logic signed [VALUE_W-1:0] req_node_value_4,
   input  logic signed [VALUE_W-1:0] req_node_value_5,
   input  logic signed [VALUE_W-1:0] req_node_value_6,
   input  logic signed [VALUE_W-1:0] req_node_value_7,
   // response
   output logic                      rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_interp_value,
   output logic signed [VALUE_W-1:0] rsp_grad_xi,
   output logic signed [VALUE_W-1:0] rsp_grad_eta,
   output logic signed [VALUE_W-1:0] rsp_grad_zeta,
   // config
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CFG_W-1:0]          csr_wdata
);

   localparam logic signed [VAL_ACC_W-1:0]  VAL_RND  = VAL_ACC_W'(1) << (VALUE_SHIFT - 1);
   localparam logic signed [GRAD_SUM_W-1:0] GRAD_RND = GRAD_SUM_W'(1) << (GRAD_SHIFT - 1);

   logic [CFG_W-1:0]      sign_tab_ff;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;

   logic signed [COORD_W-1:0] xi_ff, eta_ff, zeta_ff;
   logic signed [VALUE_W-1:0] nval_in [NODE_COUNT];
   logic signed [VALUE_W-1:0] nval_ff [NODE_COUNT];

   node_prod_type prod [NODE_COUNT];

   logic signed [HI_SUM_W-1:0]   hi3_ff [4], hi3_in [4];
   logic signed [LO_SUM_W-1:0]   lo3_ff [4], lo3_in [4];
   logic signed [GRAD_SUM_W-1:0] gx3_ff [4], gx3_in [4];
   logic signed [GRAD_SUM_W-1:0] gy3_ff [4], gy3_in [4];
   logic signed [GRAD_SUM_W-1:0] gz3_ff [4], gz3_in [4];

   logic signed [HI_SUM_W-1:0]   hi4_ff [2], hi4_in [2];
   logic signed [LO_SUM_W-1:0]   lo4_ff [2], lo4_in [2];
   logic signed [GRAD_SUM_W-1:0] gx4_ff [2], gx4_in [2];
   logic signed [GRAD_SUM_W-1:0] gy4_ff [2], gy4_in [2];
   logic signed [GRAD_SUM_W-1:0] gz4_ff [2], gz4_in [2];

   logic signed [HI_SUM_W-1:0]   hi5_ff, hi5_in;
   logic signed [LO_SUM_W-1:0]   lo5_ff, lo5_in;
   logic signed [GRAD_SUM_W-1:0] gx5_ff, gx5_in;
   logic signed [GRAD_SUM_W-1:0] gy5_ff, gy5_in;
   logic signed [GRAD_SUM_W-1:0] gz5_ff, gz5_in;

   logic signed [VAL_ACC_W-1:0]  val6_ff, val6_in;
   logic signed [GRAD_SUM_W-1:0] gx6_ff, gx6_in;
   logic signed [GRAD_SUM_W-1:0] gy6_ff, gy6_in;
   logic signed [GRAD_SUM_W-1:0] gz6_ff, gz6_in;

   logic signed [VAL_ACC_W-1:0]  val_sh;
   logic signed [GRAD_SUM_W-1:0] grad_sh [3];
   logic signed [VALUE_W-1:0]    res7_ff [4], res7_in [4];

   // handshake: no back-pressure outside reset
   assign busy      = reset;
   assign csr_ready = ~reset;

   // corner sign table
   always_ff @(posedge clock) begin
      if (reset) begin
         sign_tab_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         sign_tab_ff <= csr_wdata;
      end
   end

   // valid bits travel with the words
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 0: request capture
   always_comb begin
      nval_in[0] = req_node_value_0;
      nval_in[1] = req_node_value_1;
      nval_in[2] = req_node_value_2;
      nval_in[3] = req_node_value_3;
      nval_in[4] = req_node_value_4;
      nval_in[5] = req_node_value_5;
      nval_in[6] = req_node_value_6;
      nval_in[7] = req_node_value_7;
   end

   always_ff @(posedge clock) begin
      xi_ff   <= req_coord_xi;
      eta_ff  <= req_coord_eta;
      zeta_ff <= req_coord_zeta;
      for (int n = 0; n < NODE_COUNT; n++) begin
         nval_ff[n] <= nval_in[n];
      end
   end

   // stages 1-2: per-node multiplier slices
   for (genvar n = 0; n < NODE_COUNT; n++) begin : g_node
      hxtl_node_mul u_mul (
         .clock      (clock),
         .sign       (sign_tab_ff[SIGN_W*n +: SIGN_W]),
         .coord_xi   (xi_ff),
         .coord_eta  (eta_ff),
         .coord_zeta (zeta_ff),
         .node_value (nval_ff[n]),
         .prod       (prod[n])
      );
   end

   // stage 3: eight nodes to four
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         hi3_in[i] = HI_SUM_W'(prod[2*i].val_hi) + HI_SUM_W'(prod[2*i+1].val_hi);
         lo3_in[i] = LO_SUM_W'(prod[2*i].val_lo) + LO_SUM_W'(prod[2*i+1].val_lo);
         gx3_in[i] = GRAD_SUM_W'(prod[2*i].grad_x) + GRAD_SUM_W'(prod[2*i+1].grad_x);
         gy3_in[i] = GRAD_SUM_W'(prod[2*i].grad_y) + GRAD_SUM_W'(prod[2*i+1].grad_y);
         gz3_in[i] = GRAD_SUM_W'(prod[2*i].grad_z) + GRAD_SUM_W'(prod[2*i+1].grad_z);
      end
   end

   // stage 4: four to two
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         hi4_in[i] = hi3_ff[2*i] + hi3_ff[2*i+1];
         lo4_in[i] = lo3_ff[2*i] + lo3_ff[2*i+1];
         gx4_in[i] = gx3_ff[2*i] + gx3_ff[2*i+1];
         gy4_in[i] = gy3_ff[2*i] + gy3_ff[2*i+1];
         gz4_in[i] = gz3_ff[2*i] + gz3_ff[2*i+1];
      end
   end

   // stage 5: two to one
   always_comb begin
      hi5_in = hi4_ff[0] + hi4_ff[1];
      lo5_in = lo4_ff[0] + lo4_ff[1];
      gx5_in = gx4_ff[0] + gx4_ff[1];
      gy5_in = gy4_ff[0] + gy4_ff[1];
      gz5_in = gz4_ff[0] + gz4_ff[1];
   end

   // stage 6: join value halves, add half an LSB for rounding
   always_comb begin
      val6_in = (VAL_ACC_W'(hi5_ff) <<< SPLIT) + VAL_ACC_W'(lo5_ff) + VAL_RND;
      gx6_in  = gx5_ff + GRAD_RND;
      gy6_in  = gy5_ff + GRAD_RND;
      gz6_in  = gz5_ff + GRAD_RND;
   end

   // stage 7: scale to Q16.16 and saturate
   always_comb begin
      val_sh     = val6_ff >>> VALUE_SHIFT;
      grad_sh[0] = gx6_ff >>> GRAD_SHIFT;
      grad_sh[1] = gy6_ff >>> GRAD_SHIFT;
      grad_sh[2] = gz6_ff >>> GRAD_SHIFT;

      if (val_sh[VAL_ACC_W-1:VALUE_W-1] == '0 || val_sh[VAL_ACC_W-1:VALUE_W-1] == '1) begin
         res7_in[0] = val_sh[VALUE_W-1:0];
      end else begin
         res7_in[0] = val_sh[VAL_ACC_W-1] ? SAT_MIN : SAT_MAX;
      end

      for (int i = 0; i < 3; i++) begin
         if (grad_sh[i][GRAD_SUM_W-1:VALUE_W-1] == '0 ||
             grad_sh[i][GRAD_SUM_W-1:VALUE_W-1] == '1) begin
            res7_in[i+1] = grad_sh[i][VALUE_W-1:0];
         end else begin
            res7_in[i+1] = grad_sh[i][GRAD_SUM_W-1] ? SAT_MIN : SAT_MAX;
         end
      end
   end

   // datapath registers, stages 3 to 7
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         hi3_ff[i] <= hi3_in[i];
         lo3_ff[i] <= lo3_in[i];
         gx3_ff[i] <= gx3_in[i];
         gy3_ff[i] <= gy3_in[i];
         gz3_ff[i] <= gz3_in[i];
      end
      for (int i = 0; i < 2; i++) begin
         hi4_ff[i] <= hi4_in[i];
         lo4_ff[i] <= lo4_in[i];
         gx4_ff[i] <= gx4_in[i];
         gy4_ff[i] <= gy4_in[i];
         gz4_ff[i] <= gz4_in[i];
      end
      hi5_ff  <= hi5_in;
      lo5_ff  <= lo5_in;
      gx5_ff  <= gx5_in;
      gy5_ff  <= gy5_in;
      gz5_ff  <= gz5_in;
      val6_ff <= val6_in;
      gx6_ff  <= gx6_in;
      gy6_ff  <= gy6_in;
      gz6_ff  <= gz6_in;
      for (int i = 0; i < 4; i++) begin
         res7_ff[i] <= res7_in[i];
      end
   end

   // response
   assign rsp_valid        = vld_ff[PIPE_DEPTH-1];
   assign rsp_interp_value = res7_ff[0];
   assign rsp_grad_xi      = res7_ff[1];
   assign rsp_grad_eta     = res7_ff[2];
   assign rsp_grad_zeta    = res7_ff[3];

endmodule

// ===== rtl/hxtl_checker.sv =====
// ----------------------------------------------------------------------------
// hxtl_checker
// Port-level checks of the interpolator's latency, handshake and reset behavior.
// ----------------------------------------------------------------------------
module hxtl_checker
   import hxtl_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic csr_ready
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high just after reset");

   // every accepted word gives its result a fixed latency later
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(PIPE_DEPTH) rsp_valid)
      else $error("result missing after accepted word");

   // no result without a word accepted at the fixed latency before
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result without matching request");

   // config and requests are both open outside reset
   a_open: assert property (@(posedge clock)
      !reset |-> (!busy && csr_ready))
      else $error("channel blocked outside reset");

endmodule

bind hex8_trilinear_interpolate_grad hxtl_checker u_hxtl_checker (.*);
